### design/rgb_to_hsv_converter_defines.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_defines.svh
// Assertion macros shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: assertion failed");

// next-cycle implication
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter: assertion failed");

`else

`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, angle constants, sector codes and the divider stage payload.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 6;

  localparam int HUE_W  = 9 + HUE_FRACTION_BITS;
  localparam int FULL   = (2 ** CHANNEL_BITS) - 1;
  localparam int DEG60  = 60 * (2 ** HUE_FRACTION_BITS);
  localparam int DEG120 = 120 * (2 ** HUE_FRACTION_BITS);
  localparam int DEG240 = 240 * (2 ** HUE_FRACTION_BITS);
  localparam int DEG360 = 360 * (2 ** HUE_FRACTION_BITS);

  // hue sector quotient reaches DEG60 itself
  localparam int HQ_W      = $clog2(DEG60 + 1);
  localparam int NUM_W     = HQ_W + CHANNEL_BITS;
  localparam int SNUM_W    = 2 * CHANNEL_BITS;
  localparam int DIV_STEPS = (HQ_W > CHANNEL_BITS) ? HQ_W : CHANNEL_BITS;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [NUM_W-1:0]        hrem;
    logic [HQ_W-1:0]         hq;
    logic [SNUM_W-1:0]       srem;
    logic [CHANNEL_BITS-1:0] sq;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] vmax;
    logic                    neg;
    logic [1:0]              sector;
    logic                    gray;
  } div_t;

endpackage

### design/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB to HSV pixel converter. Takes one pixel per clock while hsv_ready does
// not stall the output. From transfer in to result, two stages find max,
// min, sector and the scaled numerators, DIV_STEPS stages of a
// one-bit-per-stage restoring divider produce the hue sector quotient and
// the saturation together (the 12-bit hue quotient sets the depth), one stage
// applies floor rounding for negative sectors and one adds the sector offset
// into the output register. Hue is in 1/64 degree, 0 up to below 360 degrees;
// gray pixels give hue and saturation zero.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    hsv_valid,
  input  logic                    hsv_ready,
  output logic [HUE_W-1:0]        hue,
  output logic [CHANNEL_BITS-1:0] saturation,
  output logic [CHANNEL_BITS-1:0] brightness
);

  // stage 1: max, min, sector
  logic                    v1;
  logic                    en1;
  logic [CHANNEL_BITS-1:0] r1;
  logic [CHANNEL_BITS-1:0] g1;
  logic [CHANNEL_BITS-1:0] b1;
  logic [CHANNEL_BITS-1:0] max1;
  logic [CHANNEL_BITS-1:0] min1;
  logic [1:0]              sec1;
  logic [CHANNEL_BITS-1:0] max_next;
  logic [CHANNEL_BITS-1:0] min_next;
  logic [1:0]              sec_next;

  // stage 2: numerators
  logic                    v2;
  logic                    en2;
  div_t                    s2;
  div_t                    s2_next;
  logic [CHANNEL_BITS-1:0] pa;
  logic [CHANNEL_BITS-1:0] pb;
  logic [CHANNEL_BITS-1:0] mag;

  // divider
  logic                    div_ready;
  logic                    div_valid;
  div_t                    div_out;

  // stage 3: signed sector value
  logic                    v3;
  logic                    en3;
  logic [HQ_W:0]           sv;
  logic [HQ_W:0]           sv_next;
  logic [HUE_W-1:0]        offset;
  logic [HUE_W-1:0]        offset_next;
  logic                    gray3;
  logic [CHANNEL_BITS-1:0] sq3;
  logic [CHANNEL_BITS-1:0] max3;

  // stage 4: output register
  logic                    v4;
  logic                    en4;

  assign en4         = !v4 || hsv_ready;
  assign en3         = !v3 || en4;
  assign en2         = !v2 || div_ready;
  assign en1         = !v1 || en2;
  assign pixel_ready = en1;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_next = SEC_RED;
      max_next = red;
    end else if (green >= blue) begin
      sec_next = SEC_GREEN;
      max_next = green;
    end else begin
      sec_next = SEC_BLUE;
      max_next = blue;
    end
    min_next = (red <= green) ? red : green;
    if (blue < min_next) begin
      min_next = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && pixel_valid) begin
      r1   <= red;
      g1   <= green;
      b1   <= blue;
      max1 <= max_next;
      min1 <= min_next;
      sec1 <= sec_next;
    end
  end

  always_comb begin
    case (sec1)
      SEC_RED: begin
        pa = g1;
        pb = b1;
      end
      SEC_GREEN: begin
        pa = b1;
        pb = r1;
      end
      default: begin
        pa = r1;
        pb = g1;
      end
    endcase
    mag             = (pa < pb) ? pb - pa : pa - pb;
    s2_next.delta   = max1 - min1;
    s2_next.hrem    = NUM_W'(mag) * NUM_W'(DEG60);
    s2_next.hq      = '0;
    s2_next.srem    = SNUM_W'(s2_next.delta) * SNUM_W'(FULL);
    s2_next.sq      = '0;
    s2_next.vmax    = max1;
    s2_next.neg     = pa < pb;
    s2_next.sector  = sec1;
    s2_next.gray    = (max1 == min1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2 <= s2_next;
    end
  end

  rgbhsv_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (div_ready),
    .in_data   (s2),
    .out_valid (div_valid),
    .out_ready (en3),
    .out_data  (div_out)
  );

  // floor rounding: -(q+1) = ~q, -q = ~q + 1
  always_comb begin
    if (!div_out.neg) begin
      sv_next = {1'b0, div_out.hq};
    end else if (|div_out.hrem) begin
      sv_next = ~{1'b0, div_out.hq};
    end else begin
      sv_next = ~{1'b0, div_out.hq} + (HQ_W + 1)'(1);
    end
    case (div_out.sector)
      SEC_RED:   offset_next = div_out.neg ? HUE_W'(DEG360) : '0;
      SEC_GREEN: offset_next = HUE_W'(DEG120);
      SEC_BLUE:  offset_next = HUE_W'(DEG240);
      default:   offset_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && div_valid) begin
      sv     <= sv_next;
      offset <= offset_next;
      gray3  <= div_out.gray;
      sq3    <= div_out.sq;
      max3   <= div_out.vmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      hue        <= gray3 ? '0 : offset + {{(HUE_W - HQ_W - 1){sv[HQ_W]}}, sv};
      saturation <= gray3 ? '0 : sq3;
      brightness <= max3;
    end
  end

  assign hsv_valid = v4;

  `RHC_ASSERT_IMPL(a_hue_range, clk, rst, hsv_valid, hue < HUE_W'(DEG360))
  `RHC_ASSERT_IMPL(a_gray_hue, clk, rst, hsv_valid && saturation == '0, hue == '0)
  `RHC_ASSERT_IMPL(a_empty_ready, clk, rst, !hsv_valid, pixel_ready)

endmodule

### design/rgbhsv_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_div_pipe
// Pipelined restoring divider, one quotient bit per stage, running the hue
// sector division and the saturation division side by side.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_div_pipe import rgbhsv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic [DIV_STEPS-1:0] v;
  logic [DIV_STEPS:0]   en;
  div_t                 stage_q [DIV_STEPS];

  assign en[DIV_STEPS] = out_ready;

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BI = DIV_STEPS - 1 - k;

      div_t                    cur;
      div_t                    nxt;
      div_t                    data_q;
      logic                    vin;
      logic                    valid_q;
      logic [NUM_W-1:0]        hrem_nx;
      logic [HQ_W-1:0]         hq_nx;
      logic [SNUM_W-1:0]       srem_nx;
      logic [CHANNEL_BITS-1:0] sq_nx;

      if (k == 0) begin : g_first
        assign cur = in_data;
        assign vin = in_valid;
      end else begin : g_rest
        assign cur = stage_q[k-1];
        assign vin = v[k-1];
      end

      if (BI < HQ_W) begin : g_hue
        logic [NUM_W-1:0] hdiv;
        logic             take;
        assign hdiv    = NUM_W'(cur.delta) << BI;
        assign take    = cur.hrem >= hdiv;
        assign hrem_nx = take ? cur.hrem - hdiv : cur.hrem;
        assign hq_nx   = cur.hq | (take ? (HQ_W'(1) << BI) : '0);
      end else begin : g_hue_idle
        assign hrem_nx = cur.hrem;
        assign hq_nx   = cur.hq;
      end

      if (BI < CHANNEL_BITS) begin : g_sat
        logic [SNUM_W-1:0] sdiv;
        logic              take;
        assign sdiv    = SNUM_W'(cur.vmax) << BI;
        assign take    = cur.srem >= sdiv;
        assign srem_nx = take ? cur.srem - sdiv : cur.srem;
        assign sq_nx   = cur.sq | (take ? (CHANNEL_BITS'(1) << BI) : '0);
      end else begin : g_sat_idle
        assign srem_nx = cur.srem;
        assign sq_nx   = cur.sq;
      end

      always_comb begin
        nxt      = cur;
        nxt.hrem = hrem_nx;
        nxt.hq   = hq_nx;
        nxt.srem = srem_nx;
        nxt.sq   = sq_nx;
      end

      assign en[k] = !valid_q || en[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q <= 1'b0;
        end else if (en[k]) begin
          valid_q <= vin;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k] && vin) begin
          data_q <= nxt;
        end
      end

      assign v[k]       = valid_q;
      assign stage_q[k] = data_q;
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[DIV_STEPS-1];
  assign out_data  = stage_q[DIV_STEPS-1];

  `RHC_ASSERT_NEXT(a_div_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `RHC_ASSERT_IMPL(a_div_hq, clk, rst, out_valid && !out_data.gray, out_data.hq <= HQ_W'(DEG60))

endmodule
